>>> sv/gnd_pkg.sv
// shared types and constants of the greedy note dispenser
`timescale 1ns / 1ps
package gnd_pkg;

  localparam int unsigned SlotCount = 8;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned UsedW     = $clog2(SlotCount + 1);
  localparam int unsigned DenomW    = 24;
  localparam int unsigned AmountW   = 32;
  localparam int unsigned StepW     = $clog2(AmountW);
  localparam int unsigned CfgIdxW   = 4;

  // one request after ordering, as it travels from front to back
  typedef struct packed {
    logic [SlotCount-1:0][DenomW-1:0] vals;
    logic [UsedW-1:0]                 used;
    logic [AmountW-1:0]               amount;
  } gnd_job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } gnd_qstat_t;

endpackage

>>> sv/gnd_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface gnd_amount_if;
  logic        valid;
  logic        ready;
  logic [31:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink   (input valid, input amount, output ready);
endinterface

interface gnd_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] denomination;
  logic [31:0] note_count;
  logic [31:0] shortfall;
  logic        last;

  modport source (output valid, output denomination, output note_count,
                  output shortfall, output last, input ready);
  modport sink   (input valid, input denomination, input note_count,
                  input shortfall, input last, output ready);
endinterface

>>> sv/greedy_note_dispenser_core.sv
// greedy note dispenser top level: front, job queue, back
//
// channel   direction  payload                                           handshake
// amount_if in         amount[31:0]                                      valid/ready
// result_if out        denomination[23:0] note_count[31:0]
//                      shortfall[31:0] last                              valid/ready
// cfg       in         cfg_idx_i[3:0] cfg_data_i[23:0]                    cfg_we_i
//
// the front takes one request, orders the denominations (one insertion step
// per slot) and pushes a job into a two-entry queue
// the back passes each used slot through a start and an emit state, with its
// 32-step shift-subtract division between them when the remainder is not zero
// the back works on the next result while the previous one waits and loads
// it when the register frees; a stalled result holds the back, a full queue
// holds the front
// reset clears the denomination registers and all control state at once
`timescale 1ns / 1ps
module greedy_note_dispenser_core #(
  parameter int unsigned NUM_DENOMS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gnd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gnd_pkg::DenomW-1:0]   cfg_data_i,
  gnd_amount_if.sink                   amount_if,
  gnd_result_if.source                 result_if
);
  import gnd_pkg::*;

  // job handoff between front and back
  logic       push;
  logic       pop;
  gnd_job_t   job_in;
  gnd_job_t   job_out;
  gnd_qstat_t qstat;

  gnd_front #(
    .NUM_DENOMS (NUM_DENOMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .amount_if  (amount_if),
    .push_o     (push),
    .job_o      (job_in),
    .qstat_i    (qstat)
  );

  // decouples ordering from the divide walk
  gnd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .qstat_o (qstat)
  );

  // one result transaction per used note (a single one when none is used), the last one carries the shortfall
  gnd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job_out),
    .qstat_i   (qstat),
    .pop_o     (pop),
    .result_if (result_if)
  );

endmodule

>>> sv/gnd_front.sv
// front end: denomination registers, request intake and stable ordering
`timescale 1ns / 1ps
module gnd_front #(
  parameter int unsigned NUM_DENOMS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gnd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gnd_pkg::DenomW-1:0]   cfg_data_i,
  gnd_amount_if.sink                   amount_if,
  output logic                         push_o,
  output gnd_pkg::gnd_job_t            job_o,
  input  gnd_pkg::gnd_qstat_t          qstat_i
);
  import gnd_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SORT = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_DENOMS - 1);

  logic [SlotCount-1:0][DenomW-1:0] denom_q;
  logic [SlotCount-1:0][DenomW-1:0] sorted_q, sorted_d;
  logic [1:0]                       state_q, state_d;
  logic [SlotW-1:0]                 slot_q, slot_d;
  logic [UsedW-1:0]                 used_q, used_d;
  logic [AmountW-1:0]               amount_q;
  logic [SlotCount-1:0]             ge;
  logic [DenomW-1:0]                v;

  // denomination registers, writes past the slot list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      denom_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(SlotCount))) begin
      denom_q[cfg_idx_i[SlotW-1:0]] <= cfg_data_i;
    end
  end

  assign v = denom_q[slot_q];

  // one insertion step: entries >= v stay, v lands after them, the rest shift up
  always_comb begin
    for (int j = 0; j < SlotCount; j++) begin
      ge[j] = (UsedW'(j) < used_q) && (sorted_q[j] >= v);
    end
    for (int j = 0; j < SlotCount; j++) begin
      if (ge[j]) begin
        sorted_d[j] = sorted_q[j];
      end else if (j == 0) begin
        sorted_d[j] = v;
      end else if (ge[j-1]) begin
        sorted_d[j] = v;
      end else begin
        sorted_d[j] = sorted_q[j-1];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    used_d  = used_q;
    case (state_q)
      F_IDLE: begin
        if (amount_if.valid) begin
          state_d = F_SORT;
          slot_d  = '0;
          used_d  = '0;
        end
      end
      F_SORT: begin
        if (v != '0) begin
          used_d = used_q + UsedW'(1);
        end
        if (slot_q == LastSlot) begin
          state_d = F_PUSH;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      F_PUSH: begin
        if (!qstat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      slot_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && amount_if.valid) begin
      amount_q <= amount_if.amount;
    end
    if (state_q == F_SORT && v != '0) begin
      sorted_q <= sorted_d;
    end
  end

  assign amount_if.ready = (state_q == F_IDLE);
  assign push_o          = (state_q == F_PUSH) && !qstat_i.full;
  assign job_o.vals      = sorted_q;
  assign job_o.used      = used_q;
  assign job_o.amount    = amount_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(NUM_DENOMS))
    else $error("front: more used slots than denominations");

  a_sort_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_SORT |=> used_q == $past(used_q) || used_q == $past(used_q) + UsedW'(1))
    else $error("front: used count jumped");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == F_SORT |-> slot_q <= LastSlot)
    else $error("front: slot cursor past the last denomination");

endmodule

>>> sv/gnd_queue.sv
// two-entry job queue between front and back
`timescale 1ns / 1ps
module gnd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gnd_pkg::gnd_job_t    job_i,
  input  logic                 pop_i,
  output gnd_pkg::gnd_job_t    job_o,
  output gnd_pkg::gnd_qstat_t  qstat_o
);
  import gnd_pkg::*;

  gnd_job_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o         = mem_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.empty = (count_q == 2'd0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full || pop_i)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("queue: pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue: count out of range");

endmodule

>>> sv/gnd_back.sv
// back end: shift-subtract divider walk over the ordered notes, result register
`timescale 1ns / 1ps
module gnd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gnd_pkg::gnd_job_t    job_i,
  input  gnd_pkg::gnd_qstat_t  qstat_i,
  output logic                 pop_o,
  gnd_result_if.source         result_if
);
  import gnd_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_START = 2'd1;
  localparam logic [1:0] B_DIV   = 2'd2;
  localparam logic [1:0] B_EMIT  = 2'd3;

  logic [1:0]                       state_q;
  logic [SlotCount-1:0][DenomW-1:0] vals_q;
  logic [UsedW-1:0]                 used_q;
  logic [SlotW-1:0]                 k_q;
  logic [AmountW-1:0]               rem_q;
  logic [AmountW-1:0]               quo_q;
  logic [DenomW-1:0]                part_q;
  logic [StepW-1:0]                 step_q;
  logic [DenomW-1:0]                d;
  logic [DenomW:0]                  shifted;
  logic                             take;
  logic [DenomW-1:0]                part_d;
  logic [AmountW-1:0]               quo_d;
  logic                             is_last;
  logic                             out_free;
  logic                             out_valid_q;

  assign d       = vals_q[k_q];
  assign shifted = {part_q, quo_q[AmountW-1]};
  assign take    = shifted >= {1'b0, d};
  assign part_d  = take ? DenomW'(shifted - {1'b0, d}) : shifted[DenomW-1:0];
  assign quo_d   = {quo_q[AmountW-2:0], take};
  assign is_last = (used_q == '0) || ({1'b0, k_q} == used_q - UsedW'(1));
  assign out_free = !out_valid_q || result_if.ready;
  assign pop_o   = (state_q == B_IDLE) && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the emit state reloads the result register on its own
      if (result_if.ready && state_q != B_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (!qstat_i.empty) begin
            k_q     <= '0;
            state_q <= B_START;
          end
        end
        B_START: begin
          step_q <= '0;
          if (used_q != '0 && rem_q != '0) begin
            state_q <= B_DIV;
          end else begin
            state_q <= B_EMIT;
          end
        end
        B_DIV: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(AmountW - 1)) begin
            state_q <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (is_last) begin
              state_q <= B_IDLE;
            end else begin
              k_q     <= k_q + SlotW'(1);
              state_q <= B_START;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          vals_q <= job_i.vals;
          used_q <= job_i.used;
          rem_q  <= job_i.amount;
        end
      end
      B_START: begin
        part_q <= '0;
        quo_q  <= (used_q != '0) ? rem_q : '0;
      end
      B_DIV: begin
        part_q <= part_d;
        quo_q  <= quo_d;
        if (step_q == StepW'(AmountW - 1)) begin
          rem_q <= AmountW'(part_d);
        end
      end
      B_EMIT: begin
        if (out_free) begin
          result_if.denomination <= (used_q == '0) ? '0 : d;
          result_if.note_count   <= quo_q;
          result_if.shortfall    <= is_last ? rem_q : '0;
          result_if.last         <= is_last;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_if.valid = out_valid_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> d != '0)
    else $error("back: division by an unused slot");

  a_part_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> part_q < d)
    else $error("back: partial remainder not below divisor");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT && used_q != '0) |-> {1'b0, k_q} < used_q)
    else $error("back: cursor past used slots");

endmodule

>>> tb/sv/greedy_note_dispenser_core_test.sv
// self-checking testbench of the greedy note dispenser core
`timescale 1ns / 1ps
module greedy_note_dispenser_core_test;
  import gnd_pkg::*;

  localparam int unsigned NumDenoms  = 8;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned TailCycles = 50;

  // one result transaction of the dispenser
  typedef struct packed {
    logic [DenomW-1:0]  denomination;
    logic [AmountW-1:0] note_count;
    logic [AmountW-1:0] shortfall;
    logic               last;
  } payout_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

  // kinds of denomination sets for the random phases
  typedef enum int unsigned {
    MIX_SMALL, MIX_WIDE, MIX_TIES, MIX_EXTREME, MIX_NOTES, MIX_EMPTY
  } denom_mix_e;

  // a write row uses idx and the low bits of value, a request row uses value as amount;
  // typed rows carry their single result, the others go through the predictor
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [AmountW-1:0] value;
    logic               typed;
    payout_t            want;
  } stim_row_t;

  localparam int unsigned NumRows = 54;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // reset state: no slot used, the whole amount is short
    '{ROW_REQUEST, 4'd0,  32'd0,           1'b1, '{24'd0, 32'd0, 32'd0, 1'b1}},
    '{ROW_REQUEST, 4'd0,  32'hFFFF_FFFF,   1'b1, '{24'd0, 32'd0, 32'hFFFF_FFFF, 1'b1}},
    // writes above the last slot are dropped
    '{ROW_WRITE,   4'd9,  32'd5,           1'b0, '0},
    '{ROW_WRITE,   4'd15, 32'h00FF_FFFF,   1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'd1234,        1'b1, '{24'd0, 32'd0, 32'd1234, 1'b1}},
    // only the top slot used, smallest note
    '{ROW_WRITE,   4'd7,  32'd1,           1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'hFFFF_FFFF,   1'b1, '{24'd1, 32'hFFFF_FFFF, 32'd0, 1'b1}},
    '{ROW_REQUEST, 4'd0,  32'd0,           1'b1, '{24'd1, 32'd0, 32'd0, 1'b1}},
    // only slot 0 used, largest note
    '{ROW_WRITE,   4'd7,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd0,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'hFFFF_FFFF,   1'b1, '{24'hFF_FFFF, 32'h100, 32'hFF, 1'b1}},
    '{ROW_REQUEST, 4'd0,  32'h00FF_FFFE,   1'b1, '{24'hFF_FFFF, 32'd0, 32'hFF_FFFE, 1'b1}},
    // all slots used, out of order
    '{ROW_WRITE,   4'd0,  32'd5,           1'b0, '0},
    '{ROW_WRITE,   4'd1,  32'd100,         1'b0, '0},
    '{ROW_WRITE,   4'd2,  32'd1,           1'b0, '0},
    '{ROW_WRITE,   4'd3,  32'd50,          1'b0, '0},
    '{ROW_WRITE,   4'd4,  32'd20,          1'b0, '0},
    '{ROW_WRITE,   4'd5,  32'd10,          1'b0, '0},
    '{ROW_WRITE,   4'd6,  32'd2,           1'b0, '0},
    '{ROW_WRITE,   4'd7,  32'd500,         1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'd0,           1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'd1888,        1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'hFFFF_FFFF,   1'b0, '0},
    // equal values and holes between used slots
    '{ROW_WRITE,   4'd0,  32'd7,           1'b0, '0},
    '{ROW_WRITE,   4'd1,  32'd7,           1'b0, '0},
    '{ROW_WRITE,   4'd2,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd3,  32'd3,           1'b0, '0},
    '{ROW_WRITE,   4'd4,  32'd7,           1'b0, '0},
    '{ROW_WRITE,   4'd5,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd6,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd7,  32'd3,           1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'd100,         1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'hFFFF_FFFF,   1'b0, '0},
    // remainder hits zero before the smaller notes
    '{ROW_WRITE,   4'd0,  32'd1000,        1'b0, '0},
    '{ROW_WRITE,   4'd1,  32'd300,         1'b0, '0},
    '{ROW_WRITE,   4'd2,  32'd7,           1'b0, '0},
    '{ROW_WRITE,   4'd3,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd4,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd5,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd6,  32'd0,           1'b0, '0},
    '{ROW_WRITE,   4'd7,  32'd0,           1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'd1000,        1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'd1307,        1'b0, '0},
    // every slot at the largest note
    '{ROW_WRITE,   4'd0,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd1,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd2,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd3,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd4,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd5,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd6,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_WRITE,   4'd7,  32'h00FF_FFFF,   1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'hFFFF_FFFF,   1'b0, '0},
    '{ROW_REQUEST, 4'd0,  32'h01FF_FFFE,   1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [DenomW-1:0]   cfg_data_i;

  gnd_amount_if amount_ch ();
  gnd_result_if result_ch ();

  // testbench copy of the denomination registers
  logic [DenomW-1:0] denom_shadow [SlotCount];
  payout_t           payout_q [$];
  payout_t           typed_want;
  logic              use_typed;
  int unsigned       idle_pct;
  int unsigned       idle_cycles;
  int unsigned       mismatches;

  greedy_note_dispenser_core #(
    .NUM_DENOMS(NumDenoms)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .amount_if  (amount_ch),
    .result_if  (result_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // stable descending order of the used notes, then greedy division down that order
  function automatic void predict_payout(input logic [AmountW-1:0] amt);
    logic [DenomW-1:0]  order [SlotCount];
    logic [DenomW-1:0]  v;
    logic [AmountW-1:0] rest;
    logic [AmountW-1:0] cnt;
    payout_t            p;
    int                 used;
    int                 pos;
    int                 s;
    int                 k;
    used = 0;
    rest = amt;
    for (s = 0; s < NumDenoms; s++) begin
      v = denom_shadow[s];
      if (v != '0) begin
        pos = used;
        while (pos > 0 && order[pos-1] < v) begin
          order[pos] = order[pos-1];
          pos--;
        end
        order[pos] = v;
        used++;
      end
    end
    if (used == 0) begin
      payout_q.push_back('{denomination: '0, note_count: '0, shortfall: amt, last: 1'b1});
      return;
    end
    for (k = 0; k < used; k++) begin
      cnt = '0;
      if (rest != '0) begin
        cnt  = rest / AmountW'(order[k]);
        rest = rest - cnt * AmountW'(order[k]);
      end
      p.denomination = order[k];
      p.note_count   = cnt;
      p.shortfall    = (k == used - 1) ? rest : '0;
      p.last         = (k == used - 1);
      payout_q.push_back(p);
    end
  endfunction

  function automatic void check_field(input string name, input logic [AmountW-1:0] want,
                                      input logic [AmountW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [DenomW-1:0] pick_denom(input denom_mix_e mix);
    int unsigned notes [10] = '{1, 2, 5, 10, 20, 50, 100, 200, 500, 1000};
    case (mix)
      MIX_SMALL:   return ($urandom_range(0, 2) == 0) ? '0 : DenomW'($urandom_range(1, 20));
      MIX_WIDE:    return ($urandom_range(0, 3) == 0) ? '0 : DenomW'($urandom);
      MIX_TIES: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return DenomW'(12);
          default: return DenomW'(3);
        endcase
      end
      MIX_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : DenomW'(1);
      MIX_NOTES:   return ($urandom_range(0, 4) == 0) ? '0 : DenomW'(notes[$urandom_range(0, 9)]);
      default:     return '0;
    endcase
  endfunction

  function automatic logic [AmountW-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
      1:       return AmountW'($urandom_range(0, 3000));
      2:       return AmountW'($urandom_range(0, 24'hFF_FFFF));
      3:       return AmountW'($urandom) >> $urandom_range(0, 31);
      default: return AmountW'($urandom);
    endcase
  endfunction

  task automatic write_denom(input logic [CfgIdxW-1:0] idx, input logic [DenomW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  // with valid still high, so a following request goes out back to back
  task automatic send_amount(input logic [AmountW-1:0] amt);
    cfg_we_i <= 1'b0;
    if ($urandom_range(0, 99) < idle_pct) begin
      amount_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    amount_ch.valid  <= 1'b1;
    amount_ch.amount <= amt;
    @(posedge clk_i);
    while (!amount_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender stays quiet until every predicted result has come out
  task automatic wait_payouts_done();
    amount_ch.valid <= 1'b0;
    while (payout_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // result side: ready drops in random bursts
  initial begin
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < idle_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
    end
  end

  // register writes, request transactions and result checks, all at the rising edge
  always @(posedge clk_i) begin
    payout_t seen;
    payout_t want;
    if (!rst_ni) begin
      foreach (denom_shadow[s]) denom_shadow[s] = '0;
      idle_cycles <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < SlotCount) denom_shadow[cfg_idx_i[SlotW-1:0]] = cfg_data_i;
      if (amount_ch.valid && amount_ch.ready) begin
        if (use_typed) payout_q.push_back(typed_want);
        else predict_payout(amount_ch.amount);
      end
      if (result_ch.valid && result_ch.ready) begin
        seen = '{result_ch.denomination, result_ch.note_count, result_ch.shortfall,
                 result_ch.last};
        if (payout_q.size() == 0) begin
          $display("%0t: result with nothing pending: denomination %0h note_count %0h shortfall %0h last %0b",
                   $time, seen.denomination, seen.note_count, seen.shortfall, seen.last);
          mismatches++;
        end else begin
          want = payout_q.pop_front();
          check_field("denomination", AmountW'(want.denomination), AmountW'(seen.denomination));
          check_field("note_count", want.note_count, seen.note_count);
          check_field("shortfall", want.shortfall, seen.shortfall);
          check_field("last", AmountW'(want.last), AmountW'(seen.last));
        end
      end
      if ((amount_ch.valid && amount_ch.ready) || (result_ch.valid && result_ch.ready) ||
          cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    wait (rst_ni === 1'b1);
    while (idle_cycles < QuietLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned slot;
    int unsigned n_req;
    denom_mix_e  mix;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    amount_ch.valid  = 1'b0;
    amount_ch.amount = '0;
    use_typed        = 1'b0;
    typed_want       = '0;
    idle_pct         = 0;
    idle_cycles      = 0;
    mismatches       = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    idle_pct = 20;
    for (int r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind == ROW_WRITE) begin
        if (r > 0 && DirectedRows[r-1].kind == ROW_REQUEST) wait_payouts_done();
        write_denom(DirectedRows[r].idx, DirectedRows[r].value[DenomW-1:0]);
      end else begin
        use_typed  = DirectedRows[r].typed;
        typed_want = DirectedRows[r].want;
        send_amount(DirectedRows[r].value);
        use_typed  = 1'b0;
      end
    end

    // random phases: new set of notes once drained, then a run of requests;
    // the last phase runs without idling on either side
    for (phase = 0; phase < NumPhases; phase++) begin
      wait_payouts_done();
      if (phase == NumPhases - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      mix = denom_mix_e'($urandom_range(MIX_SMALL, MIX_EMPTY));
      for (slot = 0; slot < SlotCount; slot++)
        write_denom(CfgIdxW'(slot), pick_denom(mix));
      if ($urandom_range(0, 3) == 0)
        write_denom(CfgIdxW'($urandom_range(SlotCount, 15)), DenomW'($urandom));
      n_req = $urandom_range(8, 12);
      repeat (n_req) send_amount(pick_amount());
    end

    wait_payouts_done();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0 && payout_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
